### hdl/page_bitmap_shift_blit_defines.svh
// Assertion macros shared by the page bitmap blit checker.
`ifndef PAGE_BITMAP_SHIFT_BLIT_DEFINES_SVH
`define PAGE_BITMAP_SHIFT_BLIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PBSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pbsb assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define PBSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pbsb assertion failed");

// Next-cycle implication that also holds across reset.
`define PBSB_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pbsb assertion failed");

`endif

### hdl/pbsb_pkg.sv
// Shared types and constants of the page bitmap blit.
package pbsb_pkg;

  localparam int MAX_WIDTH_DEF     = 128;
  localparam int DISPLAY_PAGES_DEF = 8;
  localparam int FIFO_DEPTH        = 4;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] COL_LOW_MASK  = 8'h0F;
  localparam logic [7:0] COL_HIGH_MASK = 8'hF0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef struct packed {
    logic [6:0] start_column;
    logic [5:0] start_row;
    logic [7:0] image_width;
    logic [6:0] image_height;
  } cfg_t;

  // One queued work entry: page commands and/or one data byte.
  typedef struct packed {
    logic       has_cmd;
    logic       has_data;
    logic [3:0] page;
    logic [6:0] start_column;
    logic [7:0] data;
  } entry_t;

endpackage

### hdl/pbsb_ram.sv
// Generic single-write, registered-read RAM (read-first).
module pbsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/pbsb_front.sv
// Front end: accepts source bytes, tracks row/page position, merges spill-over.
module pbsb_front #(
  parameter int MAX_WIDTH     = pbsb_pkg::MAX_WIDTH_DEF,
  parameter int DISPLAY_PAGES = pbsb_pkg::DISPLAY_PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_pixel_byte,
  input  pbsb_pkg::cfg_t   cfg,
  input  logic             fifo_full,
  output logic             push,
  output pbsb_pkg::entry_t push_entry
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = COL_W + 1;
  localparam int CS_W  = (WW + 1 > 8) ? WW + 1 : 8;

  typedef enum logic [1:0] {KIND_FIRST, KIND_MID, KIND_DRAIN} kind_t;

  logic [COL_W-1:0] cc_r, cc_nxt;
  logic [3:0]       spc_r, spc_nxt;
  logic [3:0]       page_r, page_nxt;

  logic             s1_valid_r;
  kind_t            s1_kind_r;
  logic [7:0]       s1_px_r;
  logic [2:0]       s1_shift_r;
  logic             s1_has_cmd_r;
  logic             s1_has_data_r;
  logic [3:0]       s1_page_r;
  logic [6:0]       s1_scol_r;

  logic [WW-1:0]    w_eff;
  logic [6:0]       h_eff;
  logic [3:0]       pages;
  logic [3:0]       spill_end;
  logic [2:0]       shift;
  logic             drain;
  logic             last_col;
  logic [CS_W-1:0]  col_sum;
  logic             col_ok;
  logic [3:0]       page_cur;
  logic             page_ok;
  logic             write_row;
  logic [COL_W-1:0] idx;
  logic             accept;
  kind_t            kind;
  logic [7:0]       prev;
  logic [7:0]       spill;
  logic [7:0]       shifted;
  logic [7:0]       data;
  logic             s1_busy;

  always_comb begin
    if (cfg.image_width == 8'd0) begin
      w_eff = WW'(1);
    end else if (int'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.image_width);
    end
    if (cfg.image_height == 7'd0) begin
      h_eff = 7'd1;
    end else if (cfg.image_height > 7'd64) begin
      h_eff = 7'd64;
    end else begin
      h_eff = cfg.image_height;
    end
  end

  assign shift     = cfg.start_row[2:0];
  assign pages     = 4'((h_eff + 7'd7) >> 3);
  assign spill_end = 4'((7'(shift) + h_eff - 7'd1) >> 3);
  assign drain     = (spc_r >= pages);
  assign last_col  = (WW'(cc_r) + WW'(1)) >= w_eff;
  assign col_sum   = CS_W'(cfg.start_column) + CS_W'(cc_r);
  assign col_ok    = col_sum < CS_W'(MAX_WIDTH);
  assign page_cur  = (cc_r == '0) ? (4'(cfg.start_row[5:3]) + spc_r) : page_r;
  assign page_ok   = 5'(page_cur) < 5'(DISPLAY_PAGES);
  assign write_row = page_ok && !(drain && (spill_end < pages));
  assign idx       = cc_r & COL_W'(MAX_WIDTH - 1);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (spc_r == 4'd0) begin
      kind = KIND_FIRST;
    end else if (!drain) begin
      kind = KIND_MID;
    end else begin
      kind = KIND_DRAIN;
    end
  end

  // Advance column / source page / display page.
  always_comb begin
    cc_nxt   = cc_r;
    spc_nxt  = spc_r;
    page_nxt = page_cur;
    if (last_col) begin
      cc_nxt = '0;
      if (drain) begin
        spc_nxt = 4'd0;
      end else begin
        spc_nxt = spc_r + 4'd1;
      end
    end else begin
      cc_nxt = cc_r + COL_W'(1);
    end
  end

  pbsb_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_row_buf (
    .clk  (clk),
    .we   (accept && !drain),
    .waddr(idx),
    .wdata(in_pixel_byte),
    .re   (accept),
    .raddr(idx),
    .rdata(prev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r       <= '0;
      spc_r      <= 4'd0;
      page_r     <= 4'd0;
      s1_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (accept) begin
        cc_r   <= cc_nxt;
        spc_r  <= spc_nxt;
        page_r <= page_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r     <= kind;
      s1_px_r       <= in_pixel_byte;
      s1_shift_r    <= shift;
      s1_has_cmd_r  <= write_row && (cc_r == '0);
      s1_has_data_r <= write_row && col_ok;
      s1_page_r     <= page_cur;
      s1_scol_r     <= cfg.start_column;
    end
  end

  // Merge previous page spill-over with the shifted current byte.
  assign spill   = prev >> (4'd8 - 4'(s1_shift_r));
  assign shifted = s1_px_r << s1_shift_r;

  always_comb begin
    unique case (s1_kind_r)
      KIND_FIRST: data = shifted;
      KIND_MID:   data = spill | shifted;
      KIND_DRAIN: data = spill;
      default:    data = shifted;
    endcase
  end

  assign s1_busy  = s1_valid_r && (s1_has_cmd_r || s1_has_data_r);
  assign in_stall = s1_busy && fifo_full;
  assign push     = s1_busy && !fifo_full;

  assign push_entry.has_cmd      = s1_has_cmd_r;
  assign push_entry.has_data     = s1_has_data_r;
  assign push_entry.page         = s1_page_r;
  assign push_entry.start_column = s1_scol_r;
  assign push_entry.data         = data;

endmodule

### hdl/pbsb_fifo.sv
// Short queue of work entries between front end and output sequencer.
module pbsb_fifo #(
  parameter int DEPTH = pbsb_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pbsb_pkg::entry_t push_entry,
  input  logic             pop,
  output pbsb_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pbsb_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (int'(p) == DEPTH - 1) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/pbsb_back.sv
// Output sequencer: expands queue entries into command and data transfers.
module pbsb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pbsb_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_command,
  output logic             out_last_of_run
);

  logic [1:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       cmd_r;
  logic       last_r;

  logic       load;
  logic [7:0] cur_byte;
  logic       cur_cmd;
  logic       cur_last;
  logic [7:0] scol;

  assign load = (!out_valid_r || !out_stall) && !empty;
  assign scol = 8'(head.start_column);

  always_comb begin
    cur_byte = head.data;
    cur_cmd  = 1'b0;
    cur_last = 1'b1;
    if (head.has_cmd) begin
      case (step_r)
        2'd0: begin
          cur_byte = pbsb_pkg::CMD_PAGE_BASE + 8'(head.page);
          cur_cmd  = 1'b1;
          cur_last = 1'b0;
        end
        2'd1: begin
          cur_byte = pbsb_pkg::CMD_COL_HIGH | ((scol & pbsb_pkg::COL_HIGH_MASK) >> 4);
          cur_cmd  = 1'b1;
          cur_last = 1'b0;
        end
        2'd2: begin
          cur_byte = scol & pbsb_pkg::COL_LOW_MASK;
          cur_cmd  = 1'b1;
          cur_last = !head.has_data;
        end
        default: begin
          cur_byte = head.data;
          cur_cmd  = 1'b0;
          cur_last = 1'b1;
        end
      endcase
    end
  end

  assign pop      = load && cur_last;
  assign step_nxt = cur_last ? 2'd0 : step_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= step_nxt;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      cmd_r  <= cur_cmd;
      last_r <= cur_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_is_command  = cmd_r;
  assign out_last_of_run = last_r;

endmodule

### hdl/page_bitmap_shift_blit.sv
// Top level of the page bitmap blit with vertical shift.
//
// Usage: feed a page-packed bitmap on the input channel (in_valid, in_stall,
// in_pixel_byte), one source page row of image_width bytes after another,
// followed by one drain row of image_width bytes whose values are ignored.
// Each byte is shifted down by start_row mod 8 and merged with the spill-over
// of the previous source page, kept in a one-row buffer RAM.
// Results leave on the output channel (out_valid, out_stall, out_byte,
// out_is_command, out_last_of_run). At the first column of each written page
// three address command bytes precede the data byte; out_last_of_run marks the
// final transfer caused by one input byte. Bytes past the last column or page
// produce nothing.
// An accepted input passes the front-end stage register, the queue and the
// output register. Throughput: one input per cycle while each input yields at
// most one output transfer and out_stall is low; an input at a page start
// yields four, and in_stall rises once the four-entry queue fills.
// Users must write configuration (cfg_wr_en, cfg_index, cfg_data) only while
// idle; the block does not enforce it. Reset (rst_n low, synchronous) clears
// the position counters, the queue and the output register and restores the
// register defaults; buffer contents are not cleared. While out_stall is high
// the output transfer holds, the queue fills, then in_stall holds the input.
module page_bitmap_shift_blit #(
  parameter int MAX_WIDTH     = pbsb_pkg::MAX_WIDTH_DEF,
  parameter int DISPLAY_PAGES = pbsb_pkg::DISPLAY_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_pixel_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_is_command,
  output logic                          out_last_of_run,
  input  logic                          cfg_wr_en,
  input  logic [pbsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  pbsb_pkg::cfg_t   cfg_r;
  pbsb_pkg::entry_t push_entry;
  pbsb_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             fifo_empty;
  logic             fifo_full;

  // Configuration registers; values take effect on the next input byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_column <= 7'd0;
      cfg_r.start_row    <= 6'd0;
      cfg_r.image_width  <= 8'd1;
      cfg_r.image_height <= 7'd8;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pbsb_pkg::REG_START_COLUMN: cfg_r.start_column <= cfg_data[6:0];
        pbsb_pkg::REG_START_ROW:    cfg_r.start_row    <= cfg_data[5:0];
        pbsb_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        pbsb_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Front end: position tracking, drop decisions, spill-over merge.
  pbsb_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .DISPLAY_PAGES(DISPLAY_PAGES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_byte(in_pixel_byte),
    .cfg          (cfg_r),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Decouple front end from the output sequencer.
  pbsb_fifo #(
    .DEPTH(pbsb_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  // Back end: one output transfer per cycle unless stalled or the queue is empty.
  pbsb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (fifo_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_command (out_is_command),
    .out_last_of_run(out_last_of_run)
  );

endmodule

### hdl/pbsb_checker.sv
// Port-level checker for the page bitmap blit, with its bind.
`include "page_bitmap_shift_blit_defines.svh"

module pbsb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_command,
  input logic       out_last_of_run
);

  `PBSB_ASSERT_NXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)
  `PBSB_ASSERT_IMP(a_cmd_not_last, clk, rst_n, out_valid && out_is_command, !out_last_of_run)
  `PBSB_ASSERT_IMP(a_data_is_last, clk, rst_n, out_valid && !out_is_command, out_last_of_run)
  `PBSB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_byte) && $stable(out_is_command))

endmodule

bind page_bitmap_shift_blit pbsb_checker u_pbsb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_is_command (out_is_command),
  .out_last_of_run(out_last_of_run)
);

### tb/page_bitmap_shift_blit_tb.sv
// Self-checking testbench for the page bitmap blit with vertical shift.
module page_bitmap_shift_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 6;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_W       = pbsb_pkg::MAX_WIDTH_DEF;
  localparam int PAGES_W     = pbsb_pkg::DISPLAY_PAGES_DEF;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic [7:0] value;
    logic       cmd;
    logic       last;
  } blit_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_pixel_byte = 8'h00;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_is_command;
  logic                           out_last_of_run;
  logic                           cfg_wr_en = 1'b0;
  logic [pbsb_pkg::CFG_IDX_W-1:0] cfg_index = pbsb_pkg::REG_START_COLUMN;
  logic [7:0]                     cfg_data = 8'h00;

  page_bitmap_shift_blit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_byte   (in_pixel_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_command  (out_is_command),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  // Pixel bytes waiting to be offered, and results the blit still owes.
  logic [7:0] pixel_feed[$];
  blit_word_t blit_bytes_due[$];

  // Shadow of the register file, as last written.
  logic [6:0] sh_col = 7'd0;
  logic [5:0] sh_row = 6'd0;
  logic [7:0] sh_width = 8'd1;
  logic [6:0] sh_height = 7'd8;

  // Shadow of the blit state; buffer entries start unknown in the block.
  logic [7:0] prev_row[MAX_W];
  logic [7:0] col_cnt = 8'd0;
  logic [3:0] src_page = 4'd0;
  logic [3:0] disp_page = 4'd0;

  int         errors = 0;
  int         in_accepted = 0;
  int         results_checked = 0;
  int         cmds_seen = 0;
  int         images_sent = 0;
  int         cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  blit_word_t got_word, want_word;

  // Long stretch, no random idling on either side: mid pressure image into the next.
  wire quiet = (in_accepted >= 28) && (in_accepted < 75);

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int unsigned clamp_width(input logic [7:0] w);
    if (w == 8'd0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned clamp_height(input logic [6:0] h);
    if (h == 7'd0) return 1;
    if (h > 7'd64) return 64;
    return h;
  endfunction

  // Work out the transfers one accepted pixel byte causes and advance the shadow state.
  task automatic blit_predict(input logic [7:0] pixel);
    int unsigned px, w, h, shift, pages, idx, prev, data, col;
    bit          drain, write_row;
    blit_word_t  res[4];
    int          n;
    px = pixel;
    w = clamp_width(sh_width);
    h = clamp_height(sh_height);
    shift = sh_row[2:0];
    pages = (h + 7) >> 3;
    drain = (src_page >= pages);
    write_row = 1'b1;
    n = 0;
    idx = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
    prev = prev_row[idx];

    if (col_cnt == 0) disp_page = 4'((sh_row >> 3) + src_page);

    // The drain row only exists on the display when the shift spills into it.
    if (drain && (((shift + h - 1) >> 3) < pages)) write_row = 1'b0;
    // Pages below the bottom of the display produce nothing at all.
    if (disp_page >= PAGES_W) write_row = 1'b0;

    if (write_row) begin
      if (col_cnt == 0) begin
        res[0] = '{pbsb_pkg::CMD_PAGE_BASE + 8'(disp_page), 1'b1, 1'b0};
        res[1] = '{pbsb_pkg::CMD_COL_HIGH |
                   ((8'(sh_col) & pbsb_pkg::COL_HIGH_MASK) >> 4), 1'b1, 1'b0};
        res[2] = '{8'(sh_col) & pbsb_pkg::COL_LOW_MASK, 1'b1, 1'b0};
        n = 3;
      end
      if (src_page == 0)
        data = px << shift;
      else if (!drain)
        data = (prev >> (8 - shift)) | (px << shift);
      else
        data = prev >> (8 - shift);
      // Columns past the right edge are dropped; the page commands still go out.
      col = sh_col + col_cnt;
      if (col < MAX_W) begin
        res[n] = '{data[7:0], 1'b0, 1'b0};
        n++;
      end
    end

    if (!drain) prev_row[idx] = pixel;

    if (col_cnt + 1 >= w) begin
      col_cnt = 8'd0;
      if (drain) begin
        src_page = 4'd0;
        disp_page = 4'(sh_row >> 3);
      end else begin
        src_page = src_page + 4'd1;
        disp_page = disp_page + 4'd1;
      end
    end else begin
      col_cnt = col_cnt + 8'd1;
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) blit_bytes_due.push_back(res[i]);
  endtask

  // Driver: offer queued pixel bytes; hold a stalled transfer unchanged.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        blit_predict(in_pixel_byte);
        in_accepted <= in_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_pixel_byte <= pixel_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: fires once, as soon as the pressure image is queued up,
  // so the internal queue fills and the input side has to stall.
  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (!hold_done && pixel_feed.size() > 24) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_word = '{out_byte, out_is_command, out_last_of_run};
      if (blit_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer byte=%02h cmd=%0b last=%0b",
                                out_byte, out_is_command, out_last_of_run));
      end else begin
        want_word = blit_bytes_due.pop_front();
        if (got_word != want_word)
          flag_mismatch($sformatf("got byte=%02h cmd=%0b last=%0b, want byte=%02h cmd=%0b last=%0b",
                                  got_word.value, got_word.cmd, got_word.last,
                                  want_word.value, want_word.cmd, want_word.last));
      end
      results_checked <= results_checked + 1;
      if (out_is_command) cmds_seen <= cmds_seen + 1;
    end
    out_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: fail the run at CYCLE_LIMIT, in case the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, blit_bytes_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Wait until every queued byte is taken and every owed result has arrived,
  // then give bytes that cause no result time to leave the pipeline.
  task automatic wait_idle();
    while (pixel_feed.size() != 0 || in_valid) @(posedge clk);
    while (blit_bytes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges, then drop the enable.
  task automatic write_regs(input logic [6:0] col, input logic [5:0] row,
                            input logic [7:0] w, input logic [6:0] h);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= pbsb_pkg::REG_START_COLUMN;
    cfg_data <= 8'(col);
    sh_col = col;
    @(posedge clk);
    cfg_index <= pbsb_pkg::REG_START_ROW;
    cfg_data <= 8'(row);
    sh_row = row;
    @(posedge clk);
    cfg_index <= pbsb_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w;
    sh_width = w;
    @(posedge clk);
    cfg_index <= pbsb_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= 8'(h);
    sh_height = h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Queue one whole image: every source page row plus the drain row.
  task automatic send_image(input logic [6:0] col, input logic [5:0] row,
                            input logic [7:0] w, input logic [6:0] h,
                            input bit directed, input bit write_cfg, output int count);
    logic [7:0] extremes[6];
    extremes = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'h55, 8'hAA};
    wait_idle();
    if (write_cfg) write_regs(col, row, w, h);
    count = clamp_width(w) * (((clamp_height(h) + 7) >> 3) + 1);
    for (int i = 0; i < count; i++)
      pixel_feed.push_back(directed ? extremes[i % 6] : 8'($urandom_range(0, 255)));
    images_sent++;
  endtask

  initial begin
    int n, rand_items, pick;
    logic [6:0] col, h;
    logic [5:0] row;
    logic [7:0] w;
    rand_items = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, one column, no spill into the drain row.
    send_image(7'd0, 6'd0, 8'd1, 7'd8, 1'b1, 1'b0, n);
    // Right edge and bottom page: columns past 127 dropped, spill page off screen.
    send_image(7'd126, 6'd61, 8'd4, 7'd8, 1'b1, 1'b1, n);
    // Shift 3 over two source pages, drain row not written.
    send_image(7'd0, 6'd3, 8'd3, 7'd12, 1'b1, 1'b1, n);
    // Shift 6 on a short image, drain row written with the spill-over.
    send_image(7'd96, 6'd14, 8'd2, 7'd5, 1'b1, 1'b1, n);

    // Pressure image: carries the long receiver hold-off and the stretch with
    // no idling; shift 5 spills into the drain row and the right columns drop.
    send_image(7'd116, 6'd5, 8'd16, 7'd8, 1'b0, 1'b1, n);
    // Far corner with a height beyond its limit.
    send_image(7'd127, 6'd63, 8'd2, 7'd100, 1'b0, 1'b1, n);

    while (rand_items < 30) begin
      pick = $urandom_range(0, 9);
      col = 7'($urandom_range(0, 127));
      row = 6'($urandom_range(0, 63));
      w = 8'($urandom_range(1, 10));
      h = 7'($urandom_range(1, 24));
      if (pick == 0) begin
        // Zero width and height both count as one.
        w = 8'd0;
        h = 7'd0;
      end else if (pick == 1) begin
        h = 7'($urandom_range(65, 127));
        w = 8'($urandom_range(1, 3));
      end else if (pick == 2) begin
        col = 7'($urandom_range(120, 127));
        row = 6'($urandom_range(48, 63));
      end
      send_image(col, row, w, h, 1'b0, 1'b1, n);
      rand_items += n;
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d images: %0d pixel transfers in, %0d result transfers checked (%0d commands)",
             images_sent, in_accepted, results_checked, cmds_seen);
    $display("settings spanned clamped sizes, screen edges, drain rows and a long output hold");
    if (errors == 0 && blit_bytes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pbsb_pkg.sv
hdl/pbsb_ram.sv
hdl/pbsb_front.sv
hdl/pbsb_fifo.sv
hdl/pbsb_back.sv
hdl/page_bitmap_shift_blit.sv
hdl/pbsb_checker.sv
tb/page_bitmap_shift_blit_tb.sv
